// ===== rtl/core/rsta_pkg.sv =====
// Shared types and constants for the multi-color turmite unit.
package rsta_pkg;

	localparam int CW     = 9;   // ant coordinate width, holds up to 511
	localparam int WW     = 10;  // working coordinate width before wrap
	localparam int VW     = 5;   // color working width, holds color + 1
	localparam int CELL_W = 4;
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 32;

	localparam logic [8:0]  RST_GRID_WIDTH  = 9'd256;
	localparam logic [8:0]  RST_GRID_HEIGHT = 9'd256;
	localparam logic [4:0]  RST_NUM_COLORS  = 5'd12;
	localparam logic [31:0] RST_RULE_CODES  = 32'hFF14_4405;

	typedef enum logic [1:0] {
		KIND_TICK    = 2'd0,
		KIND_RESTART = 2'd1,
		KIND_READ    = 2'd2,
		KIND_IGNORE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CODE_R    = 2'd0,
		CODE_L    = 2'd1,
		CODE_N    = 2'd2,
		CODE_NONE = 2'd3
	} rule_code_t;

	typedef enum logic [2:0] {
		CFG_GRID_WIDTH  = 3'd0,
		CFG_GRID_HEIGHT = 3'd1,
		CFG_NUM_COLORS  = 3'd2,
		CFG_RULE_CODES  = 3'd3,
		CFG_START_X     = 3'd4,
		CFG_START_Y     = 3'd5,
		CFG_START_DIR   = 3'd6
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TICK_RD,
		ST_TICK_EXEC,
		ST_REDUCE,
		ST_RD_ISSUE,
		ST_RD_DATA,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic clr_we;
		logic addr_work;
		logic exec;
		logic reduce_step;
		logic commit;
		logic cap_read;
		logic load_out;
	} rsta_cmd_t;

	typedef struct packed {
		logic  clr_last;
		logic  reduce_done;
		logic  no_action;
		kind_t kind;
	} rsta_sts_t;

endpackage

// ===== rtl/core/rsta_in_if.sv =====
// Request channel: one transaction per tick, restart or cell read.
interface rsta_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] read_x;
	logic [7:0] read_y;

	modport source (output valid, output kind, output read_x, output read_y, input ready);
	modport sink (input valid, input kind, input read_x, input read_y, output ready);
endinterface

// ===== rtl/core/rsta_out_if.sv =====
// Response channel: ant state and cell color after each request.
interface rsta_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] ant_x;
	logic [7:0] ant_y;
	logic [1:0] ant_dir;
	logic [3:0] cell_value;
	logic       moved;

	modport source (output valid, output ant_x, output ant_y, output ant_dir,
		output cell_value, output moved, input ready);
	modport sink (input valid, input ant_x, input ant_y, input ant_dir,
		input cell_value, input moved, output ready);
endinterface

// ===== rtl/core/rsta_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rsta_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule

// ===== rtl/core/rsta_ctrl.sv =====
// Controller state machine for the turmite unit.
module rsta_ctrl import rsta_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic [1:0] in_kind,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output rsta_cmd_t cmd,
	input  rsta_sts_t sts
);

	state_t state_q, state_d;
	logic   reply_q, reply_d;
	logic   out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			reply_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			reply_q     <= reply_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		reply_d  = reply_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (sts.clr_last) begin
					// a restart still owes its wrapped start position and a response
					state_d = reply_q ? ST_REDUCE : ST_IDLE;
					reply_d = 1'b0;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					case (kind_t'(in_kind))
						KIND_TICK:    state_d = ST_TICK_RD;
						KIND_RESTART: begin
							state_d = ST_CLEAR;
							reply_d = 1'b1;
						end
						KIND_READ:    state_d = ST_REDUCE;
						default:      state_d = ST_DONE;
					endcase
				end
			end
			ST_TICK_RD: begin
				state_d = ST_TICK_EXEC;
			end
			ST_TICK_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.no_action ? ST_DONE : ST_REDUCE;
			end
			ST_REDUCE: begin
				if (sts.reduce_done) begin
					if (sts.kind == KIND_READ) begin
						state_d = ST_RD_ISSUE;
					end else begin
						cmd.commit = 1'b1;
						state_d    = ST_DONE;
					end
				end else begin
					cmd.reduce_step = 1'b1;
				end
			end
			ST_RD_ISSUE: begin
				cmd.addr_work = 1'b1;
				state_d       = ST_RD_DATA;
			end
			ST_RD_DATA: begin
				cmd.cap_read = 1'b1;
				state_d      = ST_DONE;
			end
			ST_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		if (cmd.load_out) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/rsta_dp.sv =====
// Datapath: configuration, ant state, grid store, wrap unit and output register.
module rsta_dp import rsta_pkg::*; #(
	parameter int MAX_DIM    = 256,
	parameter int MAX_COLORS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_IW-1:0]   cfg_index,
	input  logic [CFG_DW-1:0]   cfg_wdata,
	input  logic [1:0]          in_kind,
	input  logic [7:0]          in_read_x,
	input  logic [7:0]          in_read_y,
	input  rsta_cmd_t           cmd,
	output rsta_sts_t           sts,
	output logic [7:0]          ant_x,
	output logic [7:0]          ant_y,
	output logic [1:0]          ant_dir,
	output logic [CELL_W-1:0]   cell_value,
	output logic                moved
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADW    = $clog2(DEPTH);
	localparam int RD_MOD = (MAX_DIM > 511) ? 511 : MAX_DIM;
	localparam int LIM    = (MAX_COLORS < 16) ? MAX_COLORS : 16;

	// configuration
	logic [8:0]  grid_width_q, grid_height_q;
	logic [4:0]  num_colors_q;
	logic [31:0] rule_codes_q;
	logic [7:0]  start_x_q, start_y_q;
	logic [1:0]  start_dir_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= RST_GRID_WIDTH;
			grid_height_q <= RST_GRID_HEIGHT;
			num_colors_q  <= RST_NUM_COLORS;
			rule_codes_q  <= RST_RULE_CODES;
			start_x_q     <= '0;
			start_y_q     <= '0;
			start_dir_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_GRID_WIDTH:  grid_width_q  <= cfg_wdata[8:0];
				CFG_GRID_HEIGHT: grid_height_q <= cfg_wdata[8:0];
				CFG_NUM_COLORS:  num_colors_q  <= cfg_wdata[4:0];
				CFG_RULE_CODES:  rule_codes_q  <= cfg_wdata[31:0];
				CFG_START_X:     start_x_q     <= cfg_wdata[7:0];
				CFG_START_Y:     start_y_q     <= cfg_wdata[7:0];
				CFG_START_DIR:   start_dir_q   <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// effective sizes
	logic [8:0] cw, ch;
	logic [4:0] ncol;

	always_comb begin
		if (grid_width_q == '0) begin
			cw = 9'd1;
		end else if (int'(grid_width_q) > MAX_DIM) begin
			cw = 9'(MAX_DIM);
		end else begin
			cw = grid_width_q;
		end
		if (grid_height_q == '0) begin
			ch = 9'd1;
		end else if (int'(grid_height_q) > MAX_DIM) begin
			ch = 9'(MAX_DIM);
		end else begin
			ch = grid_height_q;
		end
		if (num_colors_q == '0) begin
			ncol = 5'd1;
		end else if (int'(num_colors_q) > LIM) begin
			ncol = 5'(LIM);
		end else begin
			ncol = num_colors_q;
		end
	end

	// state
	kind_t           kind_q;
	logic [ADW-1:0]  clr_q;
	logic [CW-1:0]   ant_x_q, ant_y_q;
	logic [1:0]      dir_q;
	logic [WW-1:0]   wx_q, wy_q;
	logic [VW-1:0]   val_q;
	logic            moved_q;

	// grid store
	logic [ADW-1:0]    ant_addr, work_addr, raddr, waddr;
	logic              we;
	logic [CELL_W-1:0] wdata, rdata_q;

	assign ant_addr  = ADW'(ant_x_q) * ADW'(MAX_DIM) + ADW'(ant_y_q);
	assign work_addr = ADW'(wx_q) * ADW'(MAX_DIM) + ADW'(wy_q);
	assign raddr     = cmd.addr_work ? work_addr : ant_addr;
	assign waddr     = cmd.clr_we ? clr_q : ant_addr;
	assign we        = cmd.clr_we | (cmd.commit && kind_q == KIND_TICK);
	assign wdata     = cmd.clr_we ? '0 : val_q[CELL_W-1:0];

	rsta_ram #(
		.WIDTH (CELL_W),
		.DEPTH (DEPTH)
	) u_grid (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr   (raddr),
		.rdata_q (rdata_q)
	);

	// rule lookup on the color just read
	logic [3:0]     entry;
	rule_code_t     code;
	logic [1:0]     nd;
	logic [WW-1:0]  step_x, step_y;

	always_comb begin
		entry = ({1'b0, rdata_q} >= ncol) ? 4'd0 : rdata_q;
		code  = rule_code_t'(rule_codes_q[{entry, 1'b0} +: 2]);
		case (code)
			CODE_R:  nd = dir_q + 2'd1;
			CODE_L:  nd = dir_q - 2'd1;
			default: nd = dir_q;
		endcase
		step_x = {1'b0, ant_x_q};
		step_y = {1'b0, ant_y_q};
		case (nd)
			2'd0:    step_y = {1'b0, ant_y_q} + WW'(1);
			2'd1:    step_x = {1'b0, ant_x_q} + WW'(1);
			2'd2:    step_y = {1'b0, ant_y_q} + {1'b0, ch} - WW'(1);
			default: step_x = {1'b0, ant_x_q} + {1'b0, cw} - WW'(1);
		endcase
	end

	// wrap unit: subtract the modulus once a cycle until every lane is in range
	logic [WW-1:0] mx, my;

	assign mx = (kind_q == KIND_READ) ? WW'(RD_MOD) : {1'b0, cw};
	assign my = (kind_q == KIND_READ) ? WW'(RD_MOD) : {1'b0, ch};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= KIND_TICK;
			clr_q   <= '0;
			ant_x_q <= '0;
			ant_y_q <= '0;
			dir_q   <= '0;
		end else begin
			if (cmd.accept) begin
				kind_q <= kind_t'(in_kind);
				if (kind_t'(in_kind) == KIND_RESTART) begin
					dir_q <= start_dir_q;
				end
			end
			if (cmd.clr_we) begin
				clr_q <= (clr_q == ADW'(DEPTH - 1)) ? '0 : clr_q + ADW'(1);
			end
			if (cmd.exec) begin
				dir_q <= nd;
			end
			if (cmd.commit) begin
				ant_x_q <= wx_q[CW-1:0];
				ant_y_q <= wy_q[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			moved_q <= 1'b0;
			val_q   <= '0;
			if (kind_t'(in_kind) == KIND_READ) begin
				wx_q <= WW'(in_read_x);
				wy_q <= WW'(in_read_y);
			end else begin
				wx_q <= WW'(start_x_q);
				wy_q <= WW'(start_y_q);
			end
		end
		if (cmd.exec) begin
			wx_q    <= step_x;
			wy_q    <= step_y;
			moved_q <= (code != CODE_NONE);
			val_q   <= (code == CODE_NONE) ? {1'b0, rdata_q} : {1'b0, rdata_q} + VW'(1);
		end
		if (cmd.reduce_step) begin
			if (wx_q >= mx) begin
				wx_q <= wx_q - mx;
			end
			if (wy_q >= my) begin
				wy_q <= wy_q - my;
			end
			if (val_q >= ncol) begin
				val_q <= val_q - ncol;
			end
		end
		if (cmd.cap_read) begin
			val_q <= {1'b0, rdata_q};
		end
	end

	// output register
	logic [7:0]        o_x_q, o_y_q;
	logic [1:0]        o_dir_q;
	logic [CELL_W-1:0] o_val_q;
	logic              o_moved_q;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			o_x_q     <= ant_x_q[7:0];
			o_y_q     <= ant_y_q[7:0];
			o_dir_q   <= dir_q;
			o_val_q   <= val_q[CELL_W-1:0];
			o_moved_q <= moved_q;
		end
	end

	assign ant_x      = o_x_q;
	assign ant_y      = o_y_q;
	assign ant_dir    = o_dir_q;
	assign cell_value = o_val_q;
	assign moved      = o_moved_q;

	assign sts.clr_last    = (clr_q == ADW'(DEPTH - 1));
	assign sts.reduce_done = (wx_q < mx) && (wy_q < my) && (val_q < ncol);
	assign sts.no_action   = (code == CODE_NONE);
	assign sts.kind        = kind_q;

endmodule

// ===== rtl/core/rule_string_turmite_ant_unit.sv =====
// Tick: read the cell, apply its rule, wrap the step (one subtraction at most in the grid),
// commit; a tick whose rule code is none skips wrap and commit. Read: wrap the coordinates
// (needed only if MAX_DIM < 256), then read the cell. Restart: sweep the grid store to zero,
// wrap the start, then reply. One request in flight; the next is taken once the result is
// loaded, even while it waits. Reset: the same sweep zeroes the store with req.ready low;
// configuration writes are taken throughout.
module rule_string_turmite_ant_unit import rsta_pkg::*; #(
	parameter int MAX_DIM    = 256,
	parameter int MAX_COLORS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	rsta_in_if.sink           req,
	rsta_out_if.source        rsp,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_wdata
);

	rsta_cmd_t cmd;
	rsta_sts_t sts;

	rsta_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_kind   (req.kind),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	rsta_dp #(
		.MAX_DIM    (MAX_DIM),
		.MAX_COLORS (MAX_COLORS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_kind    (req.kind),
		.in_read_x  (req.read_x),
		.in_read_y  (req.read_y),
		.cmd        (cmd),
		.sts        (sts),
		.ant_x      (rsp.ant_x),
		.ant_y      (rsp.ant_y),
		.ant_dir    (rsp.ant_dir),
		.cell_value (rsp.cell_value),
		.moved      (rsp.moved)
	);

endmodule

// ===== rtl/core/rsta_chk.sv =====
// Port-level checker for the turmite unit, bound to the top level.
module rsta_chk import rsta_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic [1:0] req_kind,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] rsp_ant_x,
	input logic [7:0] rsp_ant_y,
	input logic [1:0] rsp_ant_dir,
	input logic [3:0] rsp_cell_value,
	input logic       rsp_moved
);

	// one request in flight: no new transaction right after an accept
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while previous one in flight");

	// a restart sweeps the store, so the unit stays busy while it clears
	a_restart_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_kind == KIND_RESTART) |=> !req_ready ##1 !req_ready)
		else $error("restart finished without clearing the grid");

	// a new response is loaded only as the unit returns to idle
	a_rsp_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> req_ready)
		else $error("response raised while unit still busy");

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ant_x) && $stable(rsp_ant_y)
			&& $stable(rsp_ant_dir) && $stable(rsp_cell_value) && $stable(rsp_moved))
		else $error("stalled response changed");

endmodule

bind rule_string_turmite_ant_unit rsta_chk u_rsta_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.req_kind       (req.kind),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_ant_x      (rsp.ant_x),
	.rsp_ant_y      (rsp.ant_y),
	.rsp_ant_dir    (rsp.ant_dir),
	.rsp_cell_value (rsp.cell_value),
	.rsp_moved      (rsp.moved)
);
